// ----- src/msm_pkg.sv -----
// Shared types, codes and helpers for the multislice modularity scorer.
package msm_pkg;

   // Request operation codes.
   localparam logic [1:0] OP_LABEL  = 2'd0;
   localparam logic [1:0] OP_EDGE   = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   // Response status codes.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_SELF  = 2'd2;
   localparam logic [1:0] STAT_SCORE = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_NODES    = 2'd0;
   localparam logic [1:0] CSR_SLICES   = 2'd1;
   localparam logic [1:0] CSR_GAMMA    = 2'd2;
   localparam logic [1:0] CSR_COUPLING = 2'd3;

   // Divider operand and counter widths.
   localparam int DIV_NW = 64;
   localparam int DIV_DW = 48;
   localparam int DIV_CW = 6;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_LABEL,
      S_RD_A,
      S_RD_B,
      S_DEG_A,
      S_WR_A,
      S_DEG_B,
      S_WR_B,
      S_MUL_SS,
      S_MUL_N,
      S_MUL_W,
      S_COUP,
      S_SLICE,
      S_MUL_G,
      S_DIV_NEG,
      S_FINAL,
      S_ROUND,
      S_DIV_Q,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                start;
      logic [DIV_NW-1:0]   dividend;
      logic [DIV_DW-1:0]   divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic                done;
      logic [DIV_NW-1:0]   quotient;
   } div_stat_type;

   // Saturate a positive rounded magnitude into Q1.15; a negative one is negated, not clamped.
   function automatic logic [15:0] fix_score(input logic negative, input logic [15:0] mag);
      logic [15:0] res;
      if (!negative) begin
         res = (mag > 16'd32767) ? 16'd32767 : mag;
      end else begin
         res = 16'(17'h10000 - {1'b0, mag});
      end
      return res;
   endfunction

endpackage

// ----- src/msm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module msm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/msm_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by all divisions of a score.
module msm_div (
   input  logic                  clock,
   input  logic                  reset,
   input  msm_pkg::div_ctrl_type ctrl,
   output msm_pkg::div_stat_type stat
);

   logic                          busy_ff;
   logic                          done_ff;
   logic [msm_pkg::DIV_CW-1:0]    cnt_ff;
   logic [msm_pkg::DIV_NW-1:0]    quo_ff;
   logic [msm_pkg::DIV_DW-1:0]    rem_ff;
   logic [msm_pkg::DIV_DW-1:0]    den_ff;
   logic [msm_pkg::DIV_DW:0]      trial;
   logic                          fit;

   // Shift in the next dividend bit and try the subtraction.
   always_comb begin
      trial = {rem_ff, quo_ff[msm_pkg::DIV_NW-1]};
      fit   = (trial >= {1'b0, den_ff});
   end

   // Control of the iteration.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Partial remainder and quotient; the quotient replaces the dividend bit by bit.
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         quo_ff <= ctrl.dividend;
         rem_ff <= '0;
         den_ff <= ctrl.divisor;
      end else if (busy_ff) begin
         rem_ff <= fit ? msm_pkg::DIV_DW'(trial - {1'b0, den_ff})
                       : trial[msm_pkg::DIV_DW-1:0];
         quo_ff <= {quo_ff[msm_pkg::DIV_NW-2:0], fit};
      end
   end

   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule

// ----- src/multislice_modularity_score.sv -----
// Top level of the multislice modularity scorer: sequencer, slice totals and stores.
//
//   Channel  Direction  Handshake              Word
//   req      in         req_valid / req_ready  operation, node_a, node_b, slice, label
//   rsp      out        rsp_valid / rsp_ready  status, modularity
//   csr      in         csr_wr_en              csr_index, csr_wdata
//
// An edge word makes two label reads and two read-modify-writes of the degree RAM,
// which take the single ports of the two RAMs in turn.
// A finish word runs one division per slice with edges and at most one final division,
// all on the shared 64-step divider; an empty slice is skipped.
// After reset a clearing pass writes every word of the degree RAM with req_ready low.
// The result sits in an output register, and a new word
// is only finished once the previous one has been taken.
module multislice_modularity_score #(
   parameter int MAX_NODES  = 256,
   parameter int MAX_SLICES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [7:0]         req_node_a,
   input  logic [7:0]         req_node_b,
   input  logic [2:0]         req_slice,
   input  logic [7:0]         req_label,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [15:0] rsp_modularity,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [9:0]         csr_wdata
);

   localparam int NAW = $clog2(MAX_NODES);
   localparam int SW  = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
   localparam int DAW = 8 + SW;

   msm_pkg::state_type state_ff, state_in;

   // Configuration registers.
   logic [8:0] nodes_ff;
   logic [3:0] slices_ff;
   logic [9:0] gamma_ff;
   logic [9:0] omega_ff;

   // Latched request word.
   logic [1:0] op_ff;
   logic [7:0] a_ff;
   logic [7:0] b_ff;
   logic [2:0] slice_ff;
   logic [7:0] label_ff;

   logic [7:0]  la_ff;
   logic [7:0]  lb_ff;
   logic [1:0]  status_ff;
   logic [15:0] score_ff;
   logic [DAW-1:0] clr_ff;
   logic [SW-1:0]  sidx_ff;
   logic           negative_ff;
   logic [47:0]    mul_ff;
   logic [63:0]    pos_ff;
   logic [63:0]    den_ff;
   logic [63:0]    neg_ff;

   // Per-slice totals.
   logic [15:0] twice_ff [MAX_SLICES];
   logic [15:0] same_ff  [MAX_SLICES];
   logic [31:0] sq_ff    [MAX_SLICES];

   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [15:0] rsp_mod_ff;

   logic [8:0]  n_eff;
   logic [3:0]  s_eff;
   logic [SW-1:0] slx;
   logic [15:0] twice_rd;
   logic [15:0] same_rd;
   logic [31:0] sq_rd;
   logic        out_of_range;
   logic        last_slice;

   logic [31:0] mul_a;
   logic [15:0] mul_b;

   logic           lbl_wr_en;
   logic [NAW-1:0] lbl_rd_addr;
   logic [7:0]     lbl_rd_data;
   logic           deg_wr_en;
   logic [DAW-1:0] deg_wr_addr;
   logic [15:0]    deg_wr_data;
   logic [DAW-1:0] deg_rd_addr;
   logic [15:0]    deg_rd_data;

   msm_pkg::div_ctrl_type div_ctrl;
   msm_pkg::div_stat_type div_stat;

   // Effective sizes and the slice being addressed.
   always_comb begin
      n_eff = (32'(nodes_ff) < MAX_NODES) ? nodes_ff : 9'(MAX_NODES);
      s_eff = (32'(slices_ff) < MAX_SLICES) ? slices_ff : 4'(MAX_SLICES);
      slx = (op_ff == msm_pkg::OP_FINISH) ? sidx_ff : SW'(slice_ff);
      twice_rd = twice_ff[slx];
      same_rd  = same_ff[slx];
      sq_rd    = sq_ff[slx];
      out_of_range = ({1'b0, a_ff} >= n_eff) ||
                     ((op_ff == msm_pkg::OP_EDGE) &&
                      (({1'b0, b_ff} >= n_eff) || ({1'b0, slice_ff} >= s_eff)));
      last_slice = ((5'(sidx_ff) + 5'd1) == {1'b0, s_eff});
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msm_pkg::S_CLEAR: begin
            if (clr_ff == '1) state_in = msm_pkg::S_IDLE;
         end
         msm_pkg::S_IDLE: begin
            if (req_valid) state_in = msm_pkg::S_DECODE;
         end
         msm_pkg::S_DECODE: begin
            case (op_ff)
               msm_pkg::OP_LABEL:
                  state_in = out_of_range ? msm_pkg::S_DONE : msm_pkg::S_LABEL;
               msm_pkg::OP_EDGE: begin
                  if (out_of_range || (a_ff == b_ff)) state_in = msm_pkg::S_DONE;
                  else state_in = msm_pkg::S_RD_A;
               end
               msm_pkg::OP_FINISH: state_in = msm_pkg::S_MUL_SS;
               default: state_in = msm_pkg::S_DONE;
            endcase
         end
         msm_pkg::S_LABEL:  state_in = msm_pkg::S_DONE;
         msm_pkg::S_RD_A:   state_in = msm_pkg::S_RD_B;
         msm_pkg::S_RD_B:   state_in = msm_pkg::S_DEG_A;
         msm_pkg::S_DEG_A:  state_in = msm_pkg::S_WR_A;
         msm_pkg::S_WR_A:   state_in = msm_pkg::S_DEG_B;
         msm_pkg::S_DEG_B:  state_in = msm_pkg::S_WR_B;
         msm_pkg::S_WR_B:   state_in = msm_pkg::S_DONE;
         msm_pkg::S_MUL_SS: state_in = msm_pkg::S_MUL_N;
         msm_pkg::S_MUL_N:  state_in = msm_pkg::S_MUL_W;
         msm_pkg::S_MUL_W:  state_in = msm_pkg::S_COUP;
         msm_pkg::S_COUP: begin
            state_in = (s_eff == 4'd0) ? msm_pkg::S_FINAL : msm_pkg::S_SLICE;
         end
         msm_pkg::S_SLICE: begin
            if (twice_rd != 16'd0) state_in = msm_pkg::S_MUL_G;
            else if (last_slice) state_in = msm_pkg::S_FINAL;
         end
         msm_pkg::S_MUL_G: state_in = msm_pkg::S_DIV_NEG;
         msm_pkg::S_DIV_NEG: begin
            if (div_stat.done) state_in = last_slice ? msm_pkg::S_FINAL : msm_pkg::S_SLICE;
         end
         msm_pkg::S_FINAL: begin
            state_in = (den_ff == 64'd0) ? msm_pkg::S_DONE : msm_pkg::S_ROUND;
         end
         msm_pkg::S_ROUND: begin
            state_in = (neg_ff >= den_ff) ? msm_pkg::S_DONE : msm_pkg::S_DIV_Q;
         end
         msm_pkg::S_DIV_Q: begin
            if (div_stat.done) state_in = msm_pkg::S_DONE;
         end
         msm_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = msm_pkg::S_IDLE;
         end
         default: state_in = msm_pkg::S_IDLE;
      endcase
   end

   // Outputs of the sequencer: memory ports, multiplier operands, divider start.
   always_comb begin
      req_ready   = (state_ff == msm_pkg::S_IDLE);
      lbl_wr_en   = (state_ff == msm_pkg::S_LABEL);
      lbl_rd_addr = (state_ff == msm_pkg::S_RD_B) ? NAW'(b_ff) : NAW'(a_ff);
      deg_wr_en   = 1'b0;
      deg_wr_addr = {la_ff, slx};
      deg_wr_data = deg_rd_data + 16'd1;
      deg_rd_addr = {la_ff, slx};
      mul_a       = '0;
      mul_b       = '0;
      div_ctrl.start    = 1'b0;
      div_ctrl.dividend = {mul_ff, 16'd0};
      div_ctrl.divisor  = 48'(twice_rd);
      case (state_ff)
         msm_pkg::S_CLEAR: begin
            deg_wr_en   = 1'b1;
            deg_wr_addr = clr_ff;
            deg_wr_data = '0;
         end
         msm_pkg::S_WR_A: deg_wr_en = 1'b1;
         msm_pkg::S_DEG_B: deg_rd_addr = {lb_ff, slx};
         msm_pkg::S_WR_B: begin
            deg_wr_en   = 1'b1;
            deg_wr_addr = {lb_ff, slx};
         end
         msm_pkg::S_MUL_SS: begin
            mul_a = 32'(s_eff);
            mul_b = 16'(s_eff - 4'd1);
         end
         msm_pkg::S_MUL_N: begin
            mul_a = mul_ff[31:0];
            mul_b = 16'(n_eff);
         end
         msm_pkg::S_MUL_W: begin
            mul_a = mul_ff[31:0];
            mul_b = 16'(omega_ff);
         end
         msm_pkg::S_SLICE: begin
            mul_a = sq_rd;
            mul_b = 16'(gamma_ff);
         end
         msm_pkg::S_MUL_G: div_ctrl.start = 1'b1;
         msm_pkg::S_ROUND: begin
            div_ctrl.start    = (neg_ff < den_ff);
            div_ctrl.dividend = {neg_ff[48:0], 15'd0} + {1'b0, den_ff[63:1]};
            div_ctrl.divisor  = den_ff[47:0];
         end
         default: begin
         end
      endcase
   end

   // Control registers: state, configuration, clearing pass, output handshake.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msm_pkg::S_CLEAR;
         nodes_ff     <= 9'd256;
         slices_ff    <= 4'd1;
         gamma_ff     <= 10'd128;
         omega_ff     <= 10'd128;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == msm_pkg::S_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (csr_wr_en) begin
            case (csr_index)
               msm_pkg::CSR_NODES:    nodes_ff  <= csr_wdata[8:0];
               msm_pkg::CSR_SLICES:   slices_ff <= csr_wdata[3:0];
               msm_pkg::CSR_GAMMA:    gamma_ff  <= csr_wdata;
               msm_pkg::CSR_COUPLING: omega_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
         if ((state_ff == msm_pkg::S_DONE) && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Per-slice totals, cleared by reset and updated by each in-range edge word that is not a self-loop.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SLICES; i++) begin
            twice_ff[i] <= '0;
            same_ff[i]  <= '0;
            sq_ff[i]    <= '0;
         end
      end else begin
         if (state_ff == msm_pkg::S_WR_A) begin
            sq_ff[slx] <= sq_rd + 32'({deg_rd_data, 1'b1});
         end
         if (state_ff == msm_pkg::S_WR_B) begin
            sq_ff[slx]    <= sq_rd + 32'({deg_rd_data, 1'b1});
            twice_ff[slx] <= twice_rd + 16'd2;
            if (la_ff == lb_ff) same_ff[slx] <= same_rd + 16'd1;
         end
      end
   end

   // Datapath registers of the sequencer.
   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      if (req_valid && req_ready) begin
         op_ff    <= req_operation;
         a_ff     <= req_node_a;
         b_ff     <= req_node_b;
         slice_ff <= req_slice;
         label_ff <= req_label;
      end
      case (state_ff)
         msm_pkg::S_DECODE: begin
            score_ff <= '0;
            sidx_ff  <= '0;
            case (op_ff)
               msm_pkg::OP_LABEL:  status_ff <= out_of_range ? msm_pkg::STAT_RANGE
                                                            : msm_pkg::STAT_OK;
               msm_pkg::OP_EDGE: begin
                  if (out_of_range) status_ff <= msm_pkg::STAT_RANGE;
                  else if (a_ff == b_ff) status_ff <= msm_pkg::STAT_SELF;
                  else status_ff <= msm_pkg::STAT_OK;
               end
               msm_pkg::OP_FINISH: status_ff <= msm_pkg::STAT_SCORE;
               default: status_ff <= msm_pkg::STAT_OK;
            endcase
         end
         msm_pkg::S_RD_B:  la_ff <= lbl_rd_data;
         msm_pkg::S_DEG_A: lb_ff <= lbl_rd_data;
         msm_pkg::S_COUP: begin
            pos_ff <= {mul_ff, 16'd0};
            den_ff <= {mul_ff, 16'd0};
            neg_ff <= '0;
         end
         msm_pkg::S_SLICE: begin
            pos_ff <= pos_ff + (64'(same_rd) << 25);
            den_ff <= den_ff + (64'(twice_rd) << 24);
            if ((twice_rd == 16'd0) && !last_slice) sidx_ff <= sidx_ff + 1'b1;
         end
         msm_pkg::S_DIV_NEG: begin
            if (div_stat.done) begin
               neg_ff <= neg_ff + div_stat.quotient;
               if (!last_slice) sidx_ff <= sidx_ff + 1'b1;
            end
         end
         msm_pkg::S_FINAL: begin
            negative_ff <= (neg_ff > pos_ff);
            neg_ff      <= (neg_ff > pos_ff) ? (neg_ff - pos_ff) : (pos_ff - neg_ff);
         end
         msm_pkg::S_ROUND: begin
            if (neg_ff >= den_ff) score_ff <= msm_pkg::fix_score(negative_ff, 16'h8000);
         end
         msm_pkg::S_DIV_Q: begin
            if (div_stat.done) begin
               score_ff <= msm_pkg::fix_score(negative_ff, div_stat.quotient[15:0]);
            end
         end
         default: begin
         end
      endcase
      if ((state_ff == msm_pkg::S_DONE) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_status_ff <= status_ff;
         rsp_mod_ff    <= score_ff;
      end
   end

   // Node labels; never-written entries are not read by a legal sequence.
   msm_ram #(
      .WIDTH(8),
      .DEPTH(1 << NAW)
   ) u_label_ram (
      .clock  (clock),
      .wr_en  (lbl_wr_en),
      .wr_addr(NAW'(a_ff)),
      .wr_data(label_ff),
      .rd_addr(lbl_rd_addr),
      .rd_data(lbl_rd_data)
   );

   // Degree sums per cluster and slice.
   msm_ram #(
      .WIDTH(16),
      .DEPTH(1 << DAW)
   ) u_degree_ram (
      .clock  (clock),
      .wr_en  (deg_wr_en),
      .wr_addr(deg_wr_addr),
      .wr_data(deg_wr_data),
      .rd_addr(deg_rd_addr),
      .rd_data(deg_rd_data)
   );

   msm_div u_div (
      .clock(clock),
      .reset(reset),
      .ctrl (div_ctrl),
      .stat (div_stat)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_modularity = rsp_mod_ff;

endmodule

// ----- src/msm_chk.sv -----
// Port checker for the multislice modularity scorer, bound to the top level.
module msm_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic signed [15:0] rsp_modularity
);

   // The clearing pass keeps the block closed straight after reset.
   a_clear_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request side open straight after reset");

   // Once a word is taken the block is busy on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request side open right after taking a word");

   // Only a score carries a nonzero modularity.
   a_score_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != msm_pkg::STAT_SCORE)) |-> (rsp_modularity == 16'sd0))
      else $error("modularity nonzero on a non-score word");

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_modularity)))
      else $error("response word changed while stalled");

endmodule

bind multislice_modularity_score msm_chk u_msm_chk (.*);
